FILE: src/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg: bitmap run-length decoder definitions
// Shared types, constants and helpers for the RLE8/RLE4 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package brle_pkg;

	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;

	localparam int unsigned CFG_W   = 13;
	localparam int unsigned CFG_IDX = 2;
	localparam int unsigned ROW_W   = 12;
	localparam int unsigned COL_W   = 16;

	localparam logic [COL_W-1:0] COL_MAX  = 16'hffff;
	localparam logic [7:0]       NIB_MASK = 8'h0f;
	localparam logic [7:0]       PAD_MASK = 8'd3;

	localparam logic [CFG_IDX-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX-1:0] REG_MODE   = 2'd2;

	localparam logic [7:0] ESC_EOL   = 8'd0;
	localparam logic [7:0] ESC_EOB   = 8'd1;
	localparam logic [7:0] ESC_DELTA = 8'd2;

	typedef enum logic [6:0] {
		PH_COUNT     = 7'b0000001,
		PH_RUN_VALUE = 7'b0000010,
		PH_ESCAPE    = 7'b0000100,
		PH_DELTA_X   = 7'b0001000,
		PH_DELTA_Y   = 7'b0010000,
		PH_ABS_DATA  = 7'b0100000,
		PH_ABS_PAD   = 7'b1000000
	} phase_t;

	typedef struct packed {
		phase_t           phase;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             off;
		logic [7:0]       pending;
		logic [7:0]       done;
		logic [7:0]       dx;
	} state_t;

	typedef struct packed {
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
		logic             mode;
	} cfg_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col_start;
		logic [7:0]       span_length;
		logic [7:0]       first_index;
		logic [7:0]       second_index;
		logic             end_of_image;
	} span_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             off;
	} row_pos_t;

	function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
		return (v > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : v;
	endfunction

	function automatic row_pos_t load_row(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] h;
		row_pos_t         p;
		h = (v > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : v;
		if (h == '0) begin
			p.row = '0;
			p.off = 1'b1;
		end else begin
			p.row = ROW_W'(h - CFG_W'(1));
			p.off = 1'b0;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

FILE: src/brle_byte_if.sv
// ----------------------------------------------------------------------------
// brle_byte_if: compressed byte channel
// Valid/ready channel carrying one stream byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface brle_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

FILE: src/brle_span_if.sv
// ----------------------------------------------------------------------------
// brle_span_if: pixel span channel
// Valid/ready channel carrying one decoded span or end marker per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface brle_span_if;
	logic                         valid;
	logic                         ready;
	logic [brle_pkg::ROW_W-1:0]   row;
	logic [brle_pkg::ROW_W-1:0]   col_start;
	logic [7:0]                   span_length;
	logic [7:0]                   first_index;
	logic [7:0]                   second_index;
	logic                         end_of_image;

	modport source (output valid, output row, output col_start, output span_length,
		output first_index, output second_index, output end_of_image, input ready);
	modport sink (input valid, input row, input col_start, input span_length,
		input first_index, input second_index, input end_of_image, output ready);
endinterface

`default_nettype wire

FILE: src/brle_step.sv
// ----------------------------------------------------------------------------
// brle_step: decoder next-state logic
// Parses one stream byte against the current state and forms the span.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_step (
	input  brle_pkg::state_t st,
	input  brle_pkg::cfg_t   cfg,
	input  logic [7:0]       stream_byte,
	output brle_pkg::state_t nxt,
	output brle_pkg::span_t  res,
	output logic             emit
);

	logic                          span_go;
	logic [7:0]                    span_n;
	logic [7:0]                    span_a;
	logic [7:0]                    span_b;
	logic                          add_go;
	logic [7:0]                    add_n;
	logic [brle_pkg::COL_W:0]      col_sum;
	logic                          mv_go;
	logic [7:0]                    mv_rows;
	logic [brle_pkg::CFG_W-1:0]    w;
	logic [brle_pkg::CFG_W-1:0]    room;
	logic [7:0]                    left;
	logic [7:0]                    abs_n;
	logic [7:0]                    done_next;
	logic                          pad;
	logic [7:0]                    hi_nib;
	logic [7:0]                    lo_nib;
	brle_pkg::row_pos_t            rearm;

	always_comb begin
		nxt       = st;
		res       = '0;
		emit      = 1'b0;
		span_go   = 1'b0;
		span_n    = '0;
		span_a    = '0;
		span_b    = '0;
		add_go    = 1'b0;
		add_n     = '0;
		mv_go     = 1'b0;
		mv_rows   = '0;
		w         = brle_pkg::clamp_width(cfg.width);
		room      = '0;
		rearm     = brle_pkg::load_row(cfg.height);
		hi_nib    = stream_byte >> 4;
		lo_nib    = stream_byte & brle_pkg::NIB_MASK;
		left      = (st.pending > st.done) ? (st.pending - st.done) : '0;
		if (cfg.mode) begin
			abs_n = (left < 8'd2) ? left : 8'd2;
			pad   = ((st.pending & brle_pkg::PAD_MASK) == 8'd1) ||
				((st.pending & brle_pkg::PAD_MASK) == 8'd2);
		end else begin
			abs_n = (left < 8'd1) ? left : 8'd1;
			pad   = st.pending[0];
		end
		done_next = st.done + abs_n;

		unique case (st.phase)
			brle_pkg::PH_COUNT: begin
				if (stream_byte != '0) begin
					nxt.pending = stream_byte;
					nxt.phase   = brle_pkg::PH_RUN_VALUE;
				end else begin
					nxt.phase = brle_pkg::PH_ESCAPE;
				end
			end
			brle_pkg::PH_RUN_VALUE: begin
				span_go   = 1'b1;
				span_n    = st.pending;
				span_a    = cfg.mode ? hi_nib : stream_byte;
				span_b    = cfg.mode ? lo_nib : stream_byte;
				nxt.phase = brle_pkg::PH_COUNT;
			end
			brle_pkg::PH_ESCAPE: begin
				case (stream_byte)
					brle_pkg::ESC_EOL: begin
						nxt.column = '0;
						mv_go      = 1'b1;
						mv_rows    = 8'd1;
						nxt.phase  = brle_pkg::PH_COUNT;
					end
					brle_pkg::ESC_EOB: begin
						emit             = 1'b1;
						res.end_of_image = 1'b1;
						nxt.column       = '0;
						nxt.row          = rearm.row;
						nxt.off          = rearm.off;
						nxt.phase        = brle_pkg::PH_COUNT;
					end
					brle_pkg::ESC_DELTA: begin
						nxt.phase = brle_pkg::PH_DELTA_X;
					end
					default: begin
						nxt.pending = stream_byte;
						nxt.done    = '0;
						nxt.phase   = brle_pkg::PH_ABS_DATA;
					end
				endcase
			end
			brle_pkg::PH_DELTA_X: begin
				nxt.dx    = stream_byte;
				nxt.phase = brle_pkg::PH_DELTA_Y;
			end
			brle_pkg::PH_DELTA_Y: begin
				add_go    = 1'b1;
				add_n     = st.dx;
				mv_go     = 1'b1;
				mv_rows   = stream_byte;
				nxt.phase = brle_pkg::PH_COUNT;
			end
			brle_pkg::PH_ABS_DATA: begin
				span_go  = 1'b1;
				span_n   = abs_n;
				span_a   = cfg.mode ? hi_nib : stream_byte;
				span_b   = cfg.mode ? lo_nib : stream_byte;
				nxt.done = done_next;
				if (abs_n == '0 || done_next >= st.pending) begin
					nxt.phase = pad ? brle_pkg::PH_ABS_PAD : brle_pkg::PH_COUNT;
				end
			end
			brle_pkg::PH_ABS_PAD: begin
				nxt.phase = brle_pkg::PH_COUNT;
			end
			default: begin
				nxt.phase = brle_pkg::PH_COUNT;
			end
		endcase

		if (span_go) begin
			add_go = 1'b1;
			add_n  = span_n;
			if (span_n != '0 && !st.off && st.column < brle_pkg::COL_W'(w)) begin
				room             = w - st.column[brle_pkg::CFG_W-1:0];
				emit             = 1'b1;
				res.row          = st.row;
				res.col_start    = st.column[brle_pkg::ROW_W-1:0];
				res.span_length  = (brle_pkg::CFG_W'(span_n) < room) ? span_n : room[7:0];
				res.first_index  = span_a;
				res.second_index = span_b;
			end
		end

		col_sum = {1'b0, st.column} + (brle_pkg::COL_W+1)'(add_n);
		if (add_go) begin
			nxt.column = col_sum[brle_pkg::COL_W] ? brle_pkg::COL_MAX
				: col_sum[brle_pkg::COL_W-1:0];
		end

		if (mv_go && !st.off) begin
			if (brle_pkg::ROW_W'(mv_rows) > st.row) begin
				nxt.row = '0;
				nxt.off = 1'b1;
			end else begin
				nxt.row = st.row - brle_pkg::ROW_W'(mv_rows);
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/bmp_rle_decoder.sv
// ----------------------------------------------------------------------------
// bmp_rle_decoder: bitmap RLE8/RLE4 stream decoder
// Turns a run-length compressed bitmap byte stream into clipped pixel spans.
// ----------------------------------------------------------------------------
// The decoder takes one compressed byte per clock while the span output is not
// stalled and sustains that rate with any mix of runs, escapes and absolute
// data. Each byte sits in an input register while the parse logic updates the
// decoder state and loads the result register, which drives the span output.
// The result register holds under backpressure while the input stage
// keeps taking bytes until it is full. Rows count from the bottom of the image
// upward; an end-of-bitmap escape yields a zero-length marker and re-arms the
// decoder. Write configuration only while no byte is in flight; writing the
// height reloads the starting row. No memories and no clearing pass.
`default_nettype none

module bmp_rle_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	brle_byte_if.sink                     stream,
	brle_span_if.source                   spans,
	input  logic                          cfg_we,
	input  logic [brle_pkg::CFG_IDX-1:0]  cfg_index,
	input  logic [brle_pkg::CFG_W-1:0]    cfg_data
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               advance;
	logic               out_valid_q;
	brle_pkg::span_t    out_q;
	brle_pkg::state_t   state_q;
	brle_pkg::state_t   state_nxt;
	brle_pkg::cfg_t     cfg_q;
	brle_pkg::span_t    res;
	logic               emit;
	brle_pkg::row_pos_t new_row;

	assign advance      = !out_valid_q || spans.ready;
	assign stream.ready = !valid_s1 || advance;
	assign new_row      = brle_pkg::load_row(cfg_data);

	brle_step u_step (
		.st          (state_q),
		.cfg         (cfg_q),
		.stream_byte (byte_s1),
		.nxt         (state_nxt),
		.res         (res),
		.emit        (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.stream_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= brle_pkg::PH_COUNT;
			state_q.column  <= '0;
			state_q.row     <= '0;
			state_q.off     <= 1'b0;
			state_q.pending <= '0;
			state_q.done    <= '0;
			state_q.dx      <= '0;
			cfg_q.width     <= brle_pkg::CFG_W'(1);
			cfg_q.height    <= brle_pkg::CFG_W'(1);
			cfg_q.mode      <= 1'b0;
		end else begin
			if (valid_s1 && advance) begin
				state_q <= state_nxt;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					brle_pkg::REG_WIDTH: begin
						cfg_q.width <= cfg_data;
					end
					brle_pkg::REG_HEIGHT: begin
						cfg_q.height <= cfg_data;
						state_q.row  <= new_row.row;
						state_q.off  <= new_row.off;
					end
					brle_pkg::REG_MODE: begin
						cfg_q.mode <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign spans.valid        = out_valid_q;
	assign spans.row          = out_q.row;
	assign spans.col_start    = out_q.col_start;
	assign spans.span_length  = out_q.span_length;
	assign spans.first_index  = out_q.first_index;
	assign spans.second_index = out_q.second_index;
	assign spans.end_of_image = out_q.end_of_image;

`ifndef SYNTHESIS
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.end_of_image |->
		out_q.span_length == '0 && out_q.row == '0 && out_q.col_start == '0)
		else $error("end marker carries nonzero span fields");

	a_span_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.end_of_image |-> out_q.span_length != '0)
		else $error("empty pixel span emitted");

	a_span_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.end_of_image |->
		({1'b0, out_q.col_start} + brle_pkg::CFG_W'(out_q.span_length))
		<= brle_pkg::clamp_width(cfg_q.width))
		else $error("span runs past the image width");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input stage dropped a stalled byte");
`endif

endmodule

`default_nettype wire
